// ===== rtl/glos_pkg.sv =====
// Shared types and constants for the grid line-of-sight block.
`default_nettype none

package glos_pkg;

	localparam int COORD_W   = 6;
	localparam int TILE_W    = 2;
	localparam int WIDTH_W   = 7;
	localparam int LIN_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_DOOR = 2'd2;

	localparam logic [WIDTH_W-1:0] MAP_WIDTH_RST = 7'd64;
	localparam logic [TILE_W-1:0]  FLOOR_RST     = 2'd0;
	localparam logic [TILE_W-1:0]  OPEN_DOOR_RST = 2'd3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic load;
		logic wr_tile;
		logic setup;
		logic step;
	} glos_cmd_t;

	typedef struct packed {
		logic steps_zero;
	} glos_sts_t;

endpackage

`default_nettype wire

// ===== rtl/grid_line_of_sight.sv =====
// Top level of the grid line-of-sight block: tile map with visibility queries.
//
//  Channel   Handshake          Payload
//  -------   ----------------   ------------------------------------------------
//  command   start / busy       command, tile_x, tile_y, tile_type,
//                               src_x, src_y, dst_x, dst_y
//  result    done (strobe)      visible
//  config    cfg_we             cfg_index, cfg_data
//
// A transaction on the command channel is taken at a rising edge with start high
// and busy low. A tile write completes in that same cycle and leaves busy low,
// so writes may follow one another every cycle. A query walks steps cells,
// where steps is the smaller of the major-axis distance and MAX_SIDE. Its length
// is set by the walk loop, which reads one tile per cycle through the single
// read port of the tile memory. Reset clears the controller and the
// configuration registers; the tile memory holds no reset value and is not
// cleared. The receiver cannot stall: done is high for one cycle only.
`default_nettype none

module grid_line_of_sight
	import glos_pkg::*;
#(
	parameter int MAP_DEPTH = 4096,
	parameter int MAX_SIDE  = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Command channel.
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 command,
	input  wire logic [COORD_W-1:0]   tile_x,
	input  wire logic [COORD_W-1:0]   tile_y,
	input  wire logic [TILE_W-1:0]    tile_type,
	input  wire logic [COORD_W-1:0]   src_x,
	input  wire logic [COORD_W-1:0]   src_y,
	input  wire logic [COORD_W-1:0]   dst_x,
	input  wire logic [COORD_W-1:0]   dst_y,
	// Result channel.
	output logic                      done,
	output logic                      visible,
	// Configuration write port.
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	// The controller decides when a transaction is taken and drives the
	// datapath through a small command group; the datapath reports back only
	// whether the walk has run out of steps.
	glos_cmd_t cmd;
	glos_sts_t sts;

	glos_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done)
	);

	// The datapath holds the map, the configuration and the walk registers.
	// Tile reads are registered, so each cell is checked in the cycle after its
	// address is issued; the walk does not stop early on a blocking tile but
	// simply clears the visibility flag, which keeps the schedule fixed.
	glos_datapath #(
		.MAP_DEPTH (MAP_DEPTH),
		.MAX_SIDE  (MAX_SIDE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tile_x    (tile_x),
		.tile_y    (tile_y),
		.tile_type (tile_type),
		.src_x     (src_x),
		.src_y     (src_y),
		.dst_x     (dst_x),
		.dst_y     (dst_y),
		.visible   (visible)
	);

endmodule

`default_nettype wire

// ===== rtl/glos_ctrl.sv =====
// Controller state machine that sequences one line-of-sight query.
`default_nettype none

module glos_ctrl
	import glos_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic      command,
	input  glos_sts_t      sts,
	output glos_cmd_t      cmd,
	output logic           busy,
	output logic           done
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_WALK  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_DONE);
	assign accept = start && !busy;

	assign cmd.load    = accept && (command == CMD_QUERY);
	assign cmd.wr_tile = accept && (command == CMD_WRITE);
	assign cmd.setup   = (state_q == ST_SETUP);
	assign cmd.step    = (state_q == ST_WALK) && !sts.steps_zero;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_d = ST_SETUP;
			end
			ST_SETUP: state_d = ST_WALK;
			ST_WALK: begin
				if (sts.steps_zero) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while the block is idle");
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_QUERY) |=> busy)
		else $error("accepted query did not make the block busy");
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_WRITE) |=> !busy)
		else $error("tile write left the block busy");
`endif

endmodule

`default_nettype wire

// ===== rtl/glos_datapath.sv =====
// Datapath: configuration registers, tile memory and the line walker.
`default_nettype none

module glos_datapath
	import glos_pkg::*;
#(
	parameter int MAP_DEPTH = 4096,
	parameter int MAX_SIDE  = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  glos_cmd_t                 cmd,
	output glos_sts_t                 sts,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	input  wire logic [COORD_W-1:0]   tile_x,
	input  wire logic [COORD_W-1:0]   tile_y,
	input  wire logic [TILE_W-1:0]    tile_type,
	input  wire logic [COORD_W-1:0]   src_x,
	input  wire logic [COORD_W-1:0]   src_y,
	input  wire logic [COORD_W-1:0]   dst_x,
	input  wire logic [COORD_W-1:0]   dst_y,
	output logic                      visible
);

	localparam int AW = $clog2(MAP_DEPTH);
	localparam int SW = $clog2(MAX_SIDE + 1);

	function automatic logic [LIN_W-1:0] lin_addr(
		input logic [COORD_W-1:0] y,
		input logic [WIDTH_W-1:0] w,
		input logic [COORD_W-1:0] x
	);
		logic [LIN_W-1:0] prod;
		prod = LIN_W'(y) * LIN_W'(w);
		return prod + LIN_W'(x);
	endfunction

	logic [WIDTH_W-1:0] map_width_q;
	logic [TILE_W-1:0]  floor_q;
	logic [TILE_W-1:0]  door_q;

	logic [TILE_W-1:0]  tile_mem [MAP_DEPTH];

	logic [COORD_W-1:0] sx_q, sy_q, tx_q, ty_q;
	logic [COORD_W-1:0] walk_x_q, walk_y_q;
	logic [COORD_W-1:0] err_q;
	logic [COORD_W-1:0] major_q, minor_q;
	logic               x_major_q, maj_up_q, min_up_q;
	logic [SW-1:0]      steps_q;
	logic               vis_q;

	logic [TILE_W-1:0]  rd_s1;
	logic               inrange_s1;
	logic               pend_s1;

	// Setup terms.
	logic [COORD_W-1:0] adx, ady, major, minor;
	logic               x_major;
	logic [SW-1:0]      steps_init;

	// Step terms.
	logic [COORD_W:0]   err_sum;
	logic               min_move;
	logic [COORD_W-1:0] maj_pos, min_pos, maj_next, min_next;

	logic [LIN_W-1:0]   wr_lin, rd_lin;
	logic [31:0]        wr_lin32, rd_lin32;
	logic               wr_inrange, rd_inrange;
	logic               tile_open;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q <= MAP_WIDTH_RST;
			floor_q     <= FLOOR_RST;
			door_q      <= OPEN_DOOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAP_WIDTH: map_width_q <= cfg_data[WIDTH_W-1:0];
				REG_FLOOR:     floor_q     <= cfg_data[TILE_W-1:0];
				REG_OPEN_DOOR: door_q      <= cfg_data[TILE_W-1:0];
				default: ;
			endcase
		end
	end

	assign wr_lin     = lin_addr(tile_y, map_width_q, tile_x);
	assign wr_lin32   = 32'(wr_lin);
	assign wr_inrange = (wr_lin32 < 32'(MAP_DEPTH));
	assign rd_lin     = lin_addr(walk_y_q, map_width_q, walk_x_q);
	assign rd_lin32   = 32'(rd_lin);
	assign rd_inrange = (rd_lin32 < 32'(MAP_DEPTH));

	always_ff @(posedge clk) begin
		if (cmd.wr_tile && wr_inrange) tile_mem[wr_lin32[AW-1:0]] <= tile_type;
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			rd_s1      <= tile_mem[rd_lin32[AW-1:0]];
			inrange_s1 <= rd_inrange;
		end
	end

	always_comb begin
		adx     = (sx_q > tx_q) ? (sx_q - tx_q) : (tx_q - sx_q);
		ady     = (sy_q > ty_q) ? (sy_q - ty_q) : (ty_q - sy_q);
		x_major = (adx > ady);
		major   = x_major ? adx : ady;
		minor   = x_major ? ady : adx;
		if (32'(major) < MAX_SIDE) steps_init = SW'(major);
		else                        steps_init = SW'(MAX_SIDE);
	end

	always_comb begin
		err_sum  = {1'b0, err_q} + {1'b0, minor_q};
		min_move = (err_sum > {1'b0, major_q});
		maj_pos  = x_major_q ? walk_x_q : walk_y_q;
		min_pos  = x_major_q ? walk_y_q : walk_x_q;
		maj_next = maj_up_q ? (maj_pos + 1'b1) : (maj_pos - 1'b1);
		if (min_move) min_next = min_up_q ? (min_pos + 1'b1) : (min_pos - 1'b1);
		else          min_next = min_pos;
	end

	assign tile_open = inrange_s1 && ((rd_s1 == floor_q) || (rd_s1 == door_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sx_q <= src_x;
			sy_q <= src_y;
			tx_q <= dst_x;
			ty_q <= dst_y;
		end
		if (cmd.setup) begin
			walk_x_q  <= sx_q;
			walk_y_q  <= sy_q;
			err_q     <= '0;
			major_q   <= major;
			minor_q   <= minor;
			x_major_q <= x_major;
			maj_up_q  <= x_major ? (tx_q > sx_q) : (ty_q > sy_q);
			min_up_q  <= x_major ? (ty_q > sy_q) : (tx_q > sx_q);
		end else if (cmd.step) begin
			if (x_major_q) begin
				walk_x_q <= maj_next;
				walk_y_q <= min_next;
			end else begin
				walk_y_q <= maj_next;
				walk_x_q <= min_next;
			end
			if (min_move) err_q <= err_sum[COORD_W-1:0] - major_q;
			else          err_q <= err_sum[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
			pend_s1 <= 1'b0;
			vis_q   <= 1'b1;
		end else begin
			pend_s1 <= cmd.step;
			if (cmd.setup) steps_q <= steps_init;
			else if (cmd.step) steps_q <= steps_q - 1'b1;
			if (cmd.setup) vis_q <= 1'b1;
			else if (pend_s1 && !tile_open) vis_q <= 1'b0;
		end
	end

	assign sts.steps_zero = (steps_q == '0);
	assign visible        = vis_q;

endmodule

`default_nettype wire

// ===== dv/tb_grid_line_of_sight.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for grid_line_of_sight: tile writes and visibility queries against a mirror.

module tb_grid_line_of_sight;
	import glos_pkg::*;

	// Number of tiles that the block addresses at its default size.
	localparam int MAP_CELLS = 4096;
	// Longest quiet spell in a correct run is a full-length walk plus the settling
	// pause and a sender gap; this limit is many times that.
	localparam int WATCHDOG_LIMIT = 2000;
	// Tile writes finish in the cycle they are taken, so a short pause is plenty
	// before a register write once the last result has arrived.
	localparam int SETTLE_CYCLES = 8;
	// Cycles to watch after the last result for anything unexpected.
	localparam int TAIL_CYCLES = 70;
	localparam logic [COORD_W-1:0] COORD_MAX = '1;
	// A tile code that blocks under the reset configuration.
	localparam logic [TILE_W-1:0] DIRECTED_WALL = 2'd1;

	// One command-channel transaction as the driver presents it.
	typedef struct {
		logic                command;
		logic [COORD_W-1:0]  tile_x;
		logic [COORD_W-1:0]  tile_y;
		logic [TILE_W-1:0]   tile_type;
		logic [COORD_W-1:0]  src_x;
		logic [COORD_W-1:0]  src_y;
		logic [COORD_W-1:0]  dst_x;
		logic [COORD_W-1:0]  dst_y;
	} tile_cmd_t;

	// Every input is known from time zero.
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 command   = CMD_WRITE;
	logic [COORD_W-1:0]   tile_x    = '0;
	logic [COORD_W-1:0]   tile_y    = '0;
	logic [TILE_W-1:0]    tile_type = '0;
	logic [COORD_W-1:0]   src_x     = '0;
	logic [COORD_W-1:0]   src_y     = '0;
	logic [COORD_W-1:0]   dst_x     = '0;
	logic [COORD_W-1:0]   dst_y     = '0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MAP_WIDTH;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;
	logic                 busy;
	logic                 done;
	logic                 visible;

	// Mirror of the block: its tile memory and its three registers.
	logic [TILE_W-1:0]  tile_mirror [MAP_CELLS];
	logic [WIDTH_W-1:0] row_len   = MAP_WIDTH_RST;
	logic [TILE_W-1:0]  floor_val = FLOOR_RST;
	logic [TILE_W-1:0]  door_val  = OPEN_DOOR_RST;

	// Transactions waiting for the driver, and answers waiting for the block.
	tile_cmd_t cmd_backlog [$];
	bit        visible_due [$];

	logic item_taken   = 1'b0;
	int   sender_idle_pct = 38;
	int   queued_count = 0;
	int   taken_count  = 0;
	int   quiet_cycles = 0;
	int   mismatches   = 0;
	int   writes_seen  = 0;
	int   queries_seen = 0;
	int   visible_seen = 0;
	int   settings_run = 0;

	// Open codes of the phase under way, used to shape the tiles that are written.
	logic [TILE_W-1:0] cur_floor = FLOOR_RST;
	logic [TILE_W-1:0] cur_door  = OPEN_DOOR_RST;

	grid_line_of_sight i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.tile_x    (tile_x),
		.tile_y    (tile_y),
		.tile_type (tile_type),
		.src_x     (src_x),
		.src_y     (src_y),
		.dst_x     (dst_x),
		.dst_y     (dst_y),
		.done      (done),
		.visible   (visible),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// A cell lets the line through when its linear address lies inside the map and
	// its tile holds either open code. With a zero row length every row folds onto
	// row zero, which falls out of the same sum.
	function automatic bit cell_passable(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		int unsigned       addr;
		logic [TILE_W-1:0] code;
		addr = int'(y) * int'(row_len) + int'(x);
		if (addr >= MAP_CELLS)
			return 1'b0;
		code = tile_mirror[addr];
		return (code == floor_val) || (code == door_val);
	endfunction

	// Integer line walk. One step per cell along the major axis; the error term
	// gains the minor distance each step and, once it passes the major distance,
	// the walk moves one cell on the minor axis. A tie between the distances makes
	// y the major axis. The target itself is never tested, so a query onto its own
	// source sees. The major distance never exceeds 63, so the MAX_SIDE cap on the
	// step count never bites at this size.
	function automatic bit line_clear(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
			logic [COORD_W-1:0] tx, logic [COORD_W-1:0] ty);
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		int                 adx;
		int                 ady;
		int                 major;
		int                 minor;
		int                 err;
		int                 n;
		bit                 x_major;
		bit                 maj_up;
		bit                 min_up;
		adx = (sx > tx) ? int'(sx) - int'(tx) : int'(tx) - int'(sx);
		ady = (sy > ty) ? int'(sy) - int'(ty) : int'(ty) - int'(sy);
		x_major = adx > ady;
		major = x_major ? adx : ady;
		minor = x_major ? ady : adx;
		maj_up = x_major ? (tx > sx) : (ty > sy);
		min_up = x_major ? (ty > sy) : (tx > sx);
		cx = sx;
		cy = sy;
		err = 0;
		for (n = 0; n < major; n++) begin
			if (!cell_passable(cx, cy))
				return 1'b0;
			if (x_major)
				cx = maj_up ? cx + 1'b1 : cx - 1'b1;
			else
				cy = maj_up ? cy + 1'b1 : cy - 1'b1;
			err += minor;
			if (err > major) begin
				if (x_major)
					cy = min_up ? cy + 1'b1 : cy - 1'b1;
				else
					cx = min_up ? cx + 1'b1 : cx - 1'b1;
				err -= major;
			end
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Monitor, mirror update and watchdog, all on the rising edge. The result is
	// checked before a newly taken query is predicted; the two can never belong to
	// the same transaction, since a query is answered only after its walk.
	always @(posedge clk) begin : monitor
		bit          busy_edge;
		bit          want;
		int unsigned addr;
		busy_edge = 1'b0;
		if (!arst_n) begin
			row_len = MAP_WIDTH_RST;
			floor_val = FLOOR_RST;
			door_val = OPEN_DOOR_RST;
			item_taken <= 1'b0;
		end else begin
			if (done) begin
				busy_edge = 1'b1;
				if (visible_due.size() == 0) begin
					report_mismatch("result strobe with no query waiting");
				end else begin
					want = visible_due.pop_front();
					if (visible !== want)
						report_mismatch($sformatf("visible %b, expected %b", visible, want));
				end
			end
			if (cfg_we) begin
				busy_edge = 1'b1;
				case (cfg_index)
					REG_MAP_WIDTH: row_len = cfg_data[WIDTH_W-1:0];
					REG_FLOOR:     floor_val = cfg_data[TILE_W-1:0];
					REG_OPEN_DOOR: door_val = cfg_data[TILE_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				busy_edge = 1'b1;
				taken_count++;
				if (command == CMD_WRITE) begin
					// A write beyond the map is dropped by the block.
					addr = int'(tile_y) * int'(row_len) + int'(tile_x);
					if (addr < MAP_CELLS)
						tile_mirror[addr] = tile_type;
					writes_seen++;
				end else begin
					want = line_clear(src_x, src_y, dst_x, dst_y);
					visible_due.push_back(want);
					queries_seen++;
					if (want)
						visible_seen++;
				end
			end
			item_taken <= start && !busy;
			if (busy_edge)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: %0d cycles without a transaction", WATCHDOG_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// Driver on the falling edge. A presented transaction is held until the block
	// takes it; otherwise the next one is presented, or the sender idles with junk
	// on the payload so that nothing relies on the fields while start is low.
	always @(negedge clk) begin : driver
		tile_cmd_t nxt;
		if (arst_n && !(start && !item_taken)) begin
			if (cmd_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				nxt = cmd_backlog.pop_front();
				start <= 1'b1;
				command <= nxt.command;
				tile_x <= nxt.tile_x;
				tile_y <= nxt.tile_y;
				tile_type <= nxt.tile_type;
				src_x <= nxt.src_x;
				src_y <= nxt.src_y;
				dst_x <= nxt.dst_x;
				dst_y <= nxt.dst_y;
			end else begin
				start <= 1'b0;
				command <= $urandom_range(1);
				tile_x <= $urandom_range(63);
				tile_y <= $urandom_range(63);
				tile_type <= $urandom_range(3);
				src_x <= $urandom_range(63);
				src_y <= $urandom_range(63);
				dst_x <= $urandom_range(63);
				dst_y <= $urandom_range(63);
			end
		end
	end

	// Register write on the falling edge, one cycle long.
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// The fields a write does not use carry random values.
	task automatic push_write(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [TILE_W-1:0] code);
		tile_cmd_t c;
		c.command = CMD_WRITE;
		c.tile_x = x;
		c.tile_y = y;
		c.tile_type = code;
		c.src_x = $urandom_range(63);
		c.src_y = $urandom_range(63);
		c.dst_x = $urandom_range(63);
		c.dst_y = $urandom_range(63);
		cmd_backlog.push_back(c);
		queued_count++;
	endtask

	// Likewise a query carries random write fields.
	task automatic push_query(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
			logic [COORD_W-1:0] tx, logic [COORD_W-1:0] ty);
		tile_cmd_t c;
		c.command = CMD_QUERY;
		c.tile_x = $urandom_range(63);
		c.tile_y = $urandom_range(63);
		c.tile_type = $urandom_range(3);
		c.src_x = sx;
		c.src_y = sy;
		c.dst_x = tx;
		c.dst_y = ty;
		cmd_backlog.push_back(c);
		queued_count++;
	endtask

	// Wait until every queued transaction is taken and every answer is in, then
	// give the block a few more cycles before the registers are touched.
	task automatic settle();
		while (taken_count != queued_count || visible_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly an open code of the current phase, sometimes anything at all.
	function automatic logic [TILE_W-1:0] pick_tile(int open_pct);
		if ($urandom_range(99) < open_pct)
			return $urandom_range(1) ? cur_door : cur_floor;
		return $urandom_range(3);
	endfunction

	function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] c);
		int v;
		v = int'(c) + int'($urandom_range(6)) - 3;
		if (v < 0)
			v = 0;
		if (v > 63)
			v = 63;
		return v[COORD_W-1:0];
	endfunction

	// Query end points of several shapes: a point, straight lines, true diagonals
	// (the tie that makes y the major axis), corners and edges, short hops, and
	// plain random lines.
	task automatic pick_query(output logic [COORD_W-1:0] sx, output logic [COORD_W-1:0] sy,
			output logic [COORD_W-1:0] tx, output logic [COORD_W-1:0] ty);
		int room_x;
		int room_y;
		int len;
		bit rx;
		bit ry;
		sx = $urandom_range(63);
		sy = $urandom_range(63);
		tx = $urandom_range(63);
		ty = $urandom_range(63);
		case ($urandom_range(9))
			0: begin
				tx = sx;
				ty = sy;
			end
			1: ty = sy;
			2: tx = sx;
			3: begin
				rx = $urandom_range(1);
				ry = $urandom_range(1);
				room_x = rx ? 63 - int'(sx) : int'(sx);
				room_y = ry ? 63 - int'(sy) : int'(sy);
				len = $urandom_range((room_x < room_y) ? room_x : room_y);
				tx = rx ? sx + len[COORD_W-1:0] : sx - len[COORD_W-1:0];
				ty = ry ? sy + len[COORD_W-1:0] : sy - len[COORD_W-1:0];
			end
			4: begin
				sx = $urandom_range(1) ? COORD_MAX : '0;
				sy = $urandom_range(1) ? COORD_MAX : '0;
				tx = $urandom_range(1) ? COORD_MAX : '0;
				ty = $urandom_range(1) ? COORD_MAX : '0;
			end
			5: begin
				tx = near_coord(sx);
				ty = near_coord(sy);
			end
			default: ;
		endcase
	endtask

	// One register setting. The map is first repainted at row length 64, which
	// reaches every address, so no query ever reads a tile that was never written.
	// Nearly every painted tile is open under the phase's codes, so that lines get
	// far before they meet a wall. Then the row length of the phase is set and the
	// directed opening, if asked for, and the random transactions follow.
	task automatic run_phase(bit with_directed, logic [WIDTH_W-1:0] width,
			logic [TILE_W-1:0] flr, logic [TILE_W-1:0] door, int idle_pct, int n_items);
		logic [CFG_DAT_W-1:0] d;
		logic [COORD_W-1:0]   sx;
		logic [COORD_W-1:0]   sy;
		logic [COORD_W-1:0]   tx;
		logic [COORD_W-1:0]   ty;
		logic [COORD_W:0]     mid_x;
		logic [COORD_W:0]     mid_y;
		int                   made;
		int                   r;
		int                   x;
		int                   y;
		sender_idle_pct = idle_pct;
		cur_floor = flr;
		cur_door = door;
		settings_run++;
		// Unused upper bits of the data for the code registers carry random values.
		cfg_write(REG_MAP_WIDTH, CFG_DAT_W'(64));
		d = $urandom;
		d[TILE_W-1:0] = flr;
		cfg_write(REG_FLOOR, d);
		d = $urandom;
		d[TILE_W-1:0] = door;
		cfg_write(REG_OPEN_DOOR, d);
		for (y = 0; y < 64; y++)
			for (x = 0; x < 64; x++)
				push_write(x[COORD_W-1:0], y[COORD_W-1:0], pick_tile(97));
		settle();
		cfg_write(REG_MAP_WIDTH, CFG_DAT_W'(width));

		if (with_directed) begin
			// Directed opening under the reset codes: a query onto its own source,
			// full-length lines on both axes and both diagonals, a wall on the
			// source, a wall on the target (never tested), a wall in mid-line,
			// an open door in its place, and writes at the corners.
			push_query(6'd5, 6'd5, 6'd5, 6'd5);
			push_query('0, '0, COORD_MAX, '0);
			push_query('0, '0, '0, COORD_MAX);
			push_query(COORD_MAX, COORD_MAX, '0, '0);
			push_query('0, COORD_MAX, COORD_MAX, '0);
			push_query(6'd10, 6'd10, 6'd13, 6'd12);
			push_query(6'd20, 6'd20, 6'd21, 6'd40);
			push_write('0, '0, DIRECTED_WALL);
			push_query('0, '0, COORD_MAX, '0);
			push_query(6'd1, '0, '0, '0);
			push_write('0, '0, FLOOR_RST);
			push_write(6'd31, '0, FLOOR_RST);
			push_write(6'd32, '0, DIRECTED_WALL);
			push_query('0, '0, COORD_MAX, '0);
			push_query('0, '0, 6'd32, '0);
			push_write(6'd32, '0, OPEN_DOOR_RST);
			push_query('0, '0, COORD_MAX, '0);
			push_write(COORD_MAX, COORD_MAX, 2'd2);
			push_write(COORD_MAX, '0, OPEN_DOOR_RST);
			push_query(COORD_MAX, COORD_MAX, '0, COORD_MAX);
			push_query('0, COORD_MAX, COORD_MAX, COORD_MAX);
		end

		made = 0;
		while (made < n_items) begin
			r = $urandom_range(99);
			if (r < 25) begin
				push_write($urandom_range(63), $urandom_range(63), pick_tile(70));
				made += 1;
			end else if (r < 32) begin
				// Ask, drop a tile near the middle of the line, and ask again.
				pick_query(sx, sy, tx, ty);
				push_query(sx, sy, tx, ty);
				mid_x = ({1'b0, sx} + {1'b0, tx}) >> 1;
				mid_y = ({1'b0, sy} + {1'b0, ty}) >> 1;
				push_write(mid_x[COORD_W-1:0], mid_y[COORD_W-1:0], $urandom_range(3));
				push_query(sx, sy, tx, ty);
				made += 3;
			end else begin
				pick_query(sx, sy, tx, ty);
				push_query(sx, sy, tx, ty);
				made += 1;
			end
		end
		settle();
	endtask

	// Stimulus: reset once, then seven register settings. The sender idles often
	// in the first three, far more in the next two, and not at all in the last two.
	// The settings take in the smallest nonzero and largest row lengths, a zero row length,
	// a length that pushes far rows beyond the map, and equal floor and door codes.
	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		run_phase(1'b1, MAP_WIDTH_RST, FLOOR_RST, OPEN_DOOR_RST, 38, 160);
		run_phase(1'b0, 7'd1, 2'd2, 2'd1, 38, 180);
		run_phase(1'b0, 7'd127, 2'd3, 2'd3, 38, 180);
		run_phase(1'b0, 7'd0, 2'd1, 2'd0, 78, 180);
		run_phase(1'b0, 7'd33, 2'd2, 2'd3, 78, 180);
		run_phase(1'b0, 7'd64, 2'd1, 2'd2, 0, 180);
		run_phase(1'b0, 7'd63, 2'd3, 2'd0, 0, 180);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (visible_due.size() != 0)
			report_mismatch($sformatf("%0d queries never answered", visible_due.size()));
		$display("Run covered %0d tile writes and %0d queries, %0d of them visible,",
			writes_seen, queries_seen, visible_seen);
		$display("across %0d register settings with row lengths from 0 to 127.", settings_run);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/glos_pkg.sv
rtl/glos_ctrl.sv
rtl/glos_datapath.sv
rtl/grid_line_of_sight.sv
dv/tb_grid_line_of_sight.sv
